### design/sensor_range_autocal_detent_assert.svh
// Assertion macros shared by the calibration block.
// Include by bare file name at the end of a module; needs clk and rst in scope.
`ifndef SENSOR_RANGE_AUTOCAL_DETENT_ASSERT_SVH
`define SENSOR_RANGE_AUTOCAL_DETENT_ASSERT_SVH

// Same-cycle implication, off during reset
`define SRACD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sracd assertion failed");

// Next-cycle implication, off during reset
`define SRACD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sracd assertion failed");

`endif

### design/sracd_pkg.sv
// Types, codes and helper functions of the sensor range calibration block.
// No dependencies; imported by sracd_calc, the top module and the testbench.
package sracd_pkg;

  // Request codes
  localparam logic [1:0] REQ_SAMPLE   = 2'd0;
  localparam logic [1:0] REQ_SET_LOW  = 2'd1;
  localparam logic [1:0] REQ_SET_HIGH = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_RESOLUTION = 2'd0;
  localparam logic [1:0] CFG_ACTIVE     = 2'd1;
  localparam logic [1:0] CFG_MASK       = 2'd2;

  // Register reset values
  localparam logic [4:0]  RESOLUTION_RESET = 5'd12;
  localparam logic [4:0]  ACTIVE_RESET     = 5'd16;
  localparam logic [15:0] MASK_RESET       = 16'd0;

  // Widest converter and number of channels with a mask bit
  localparam logic [4:0] MAX_RES_BITS = 5'd16;
  localparam logic [7:0] MASK_CHANNELS = 8'd16;

  // Detent half-width is range / (2 * DEADZONE_DEN) = range / 40.
  // Done as (range >> 3) / 5, the divide by 5 as a reciprocal multiply,
  // exact for the 13-bit operand.
  localparam int          DEADZONE_DEN = 20;
  localparam int          HALF_PRESHIFT = 3;
  localparam logic [15:0] RECIP_MUL = 16'd52429;
  localparam int          RECIP_SHIFT = 18;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  channel;
    logic [15:0] value_in;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [15:0] value_out;
    logic        chan_enabled;
    logic [15:0] min_seen;
    logic [15:0] max_seen;
    logic [15:0] detent_low;
    logic [15:0] detent_high;
  } rsp_t;

  // One channel's calibration row, as stored in the table memory
  typedef struct packed {
    logic [15:0] min_v;
    logic [15:0] max_v;
    logic [15:0] dlo;
    logic [15:0] dhi;
  } row_t;

  typedef struct packed {
    logic        we;
    row_t        row;
  } wr_t;

  typedef struct packed {
    logic [4:0]  resolution_bits;
    logic [4:0]  active_channels;
    logic [15:0] channel_enable_mask;
  } cfg_t;

  // Converter full scale: 2^bits, or 65535 from 16 bits upwards
  function automatic logic [15:0] conv_max(input logic [4:0] bits);
    logic [16:0] pow;
    pow = 17'd1 << bits[3:0];
    if (bits >= MAX_RES_BITS) begin
      return 16'hFFFF;
    end
    return pow[15:0];
  endfunction

  // Row of a channel that has not been touched since the last table init
  function automatic row_t init_row(input logic [15:0] m);
    row_t r;
    r.min_v = m;
    r.max_v = 16'd0;
    r.dlo   = 16'd0;
    r.dhi   = m;
    return r;
  endfunction

endpackage

### design/sracd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sracd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/sracd_calc.sv
// Per-item calibration datapath: clamp, min/max update, detent window, set requests.
// Depends on sracd_pkg.
module sracd_calc
  import sracd_pkg::*;
#(
  parameter int NUM_CHANNELS = 16
) (
  input  req_t item,
  input  row_t row,
  input  cfg_t cfg,
  output rsp_t rsp,
  output wr_t  wr
);

  localparam logic [7:0] NUM_CH_L = 8'(NUM_CHANNELS);

  logic        chan_ok;
  logic        en;
  logic [15:0] m;
  logic [15:0] v;
  logic [15:0] mn;
  logic [15:0] mx0;
  logic [15:0] mx;
  logic [15:0] rng;
  logic [15:0] rng1;
  logic [15:0] ctr;
  logic [12:0] r8;
  logic [28:0] prod;
  logic [15:0] half;
  logic [15:0] lo;
  logic [16:0] hi_w;
  logic [15:0] hi;
  row_t        row_new;

  // Channel checks
  always_comb begin
    chan_ok = (item.channel < {3'b000, cfg.active_channels}) && (item.channel < NUM_CH_L);
    en = (item.channel < MASK_CHANNELS) ? cfg.channel_enable_mask[item.channel[3:0]] : 1'b0;
  end

  // Clamp and track the observed range
  always_comb begin
    m    = conv_max(cfg.resolution_bits);
    v    = (item.value_in > m) ? m : item.value_in;
    mn   = (v < row.min_v) ? v : row.min_v;
    mx0  = (v > row.max_v) ? v : row.max_v;
    mx   = (mx0 < mn) ? mn : mx0;
    rng  = mx - mn;
    rng1 = (rng == 16'd0) ? 16'd1 : rng;
    ctr  = mn + (rng1 >> 1);
  end

  // Detent window: centre +/- range/40, floored at zero, saturated at full scale
  always_comb begin
    r8   = rng1[15:HALF_PRESHIFT];
    prod = r8 * RECIP_MUL;
    half = 16'(prod >> RECIP_SHIFT);
    lo   = (ctr > half) ? (ctr - half) : 16'd0;
    hi_w = {1'b0, ctr} + {1'b0, half};
    hi   = (hi_w > {1'b0, m}) ? m : hi_w[15:0];
  end

  // Decode the request and build the result and the row write
  always_comb begin
    rsp     = '0;
    row_new = row;
    wr.we   = 1'b0;
    if (!chan_ok) begin
      rsp.status = 1'b1;
    end else begin
      case (item.req_type)
        REQ_SAMPLE: begin
          rsp.value_out = v;
          if (en) begin
            row_new.min_v = mn;
            row_new.max_v = mx;
            row_new.dlo   = lo;
            row_new.dhi   = hi;
            wr.we         = 1'b1;
          end
        end
        REQ_SET_LOW: begin
          if (en) begin
            row_new.dlo = item.value_in;
            wr.we       = 1'b1;
          end else begin
            rsp.status = 1'b1;
          end
        end
        REQ_SET_HIGH: begin
          if (en) begin
            row_new.dhi = item.value_in;
            wr.we       = 1'b1;
          end else begin
            rsp.status = 1'b1;
          end
        end
        default: begin
          rsp.status = 1'b1;
        end
      endcase
      rsp.chan_enabled = en;
      rsp.min_seen     = row_new.min_v;
      rsp.max_seen     = row_new.max_v;
      rsp.detent_low   = row_new.dlo;
      rsp.detent_high  = row_new.dhi;
    end
    wr.row = row_new;
  end

endmodule

### design/sensor_range_autocal_detent.sv
// Throughput: one request per cycle while rsp_stall does not hold the stages, on
// any mix of channels; the table memory is read at accept and written as the item
// leaves the working stage, with a forwarding register covering back-to-back
// beats on the same channel.
// Reset (rst, synchronous): registers to 12 bits / 16 channels / mask 0, tables
// reinitialised at once by clearing per-channel valid bits; no clearing pass.
module sensor_range_autocal_detent
  import sracd_pkg::*;
#(
  parameter int NUM_CHANNELS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int VLD_N = 1 << CH_W;

  cfg_t             cfg;
  logic [VLD_N-1:0] vld;
  logic             s1_full;
  req_t             s1_item;
  logic             s1_vld;
  logic             byp_hit;
  row_t             byp_row;
  logic             out_full;
  logic             accept;
  logic             s1_adv;
  logic [CH_W-1:0]  rd_idx;
  logic [CH_W-1:0]  wr_idx;
  row_t             ram_row;
  row_t             s1_row;
  rsp_t             rsp_next;
  wr_t              wr;
  logic             ram_we;

  // Handshake
  always_comb begin
    s1_adv    = s1_full && (!out_full || !rsp_stall);
    req_stall = s1_full && !s1_adv;
    accept    = req_valid && !req_stall;
    rd_idx    = req.channel[CH_W-1:0];
    wr_idx    = s1_item.channel[CH_W-1:0];
    ram_we    = s1_adv && wr.we;
    rsp_valid = out_full;
    cfg_ready = 1'b1;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.resolution_bits     <= RESOLUTION_RESET;
      cfg.active_channels     <= ACTIVE_RESET;
      cfg.channel_enable_mask <= MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RESOLUTION: cfg.resolution_bits     <= cfg_data[4:0];
        CFG_ACTIVE:     cfg.active_channels     <= cfg_data[4:0];
        CFG_MASK:       cfg.channel_enable_mask <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Row valid bits: drop all on reset or resolution write, set on row write
  always_ff @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready && (cfg_index == CFG_RESOLUTION))) begin
      vld <= '0;
    end else if (ram_we) begin
      vld[wr_idx] <= 1'b1;
    end
  end

  // Calibration table: one row of four values per channel
  sracd_ram #(
    .WIDTH($bits(row_t)),
    .DEPTH(NUM_CHANNELS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_idx),
    .wdata(wr.row),
    .re   (accept),
    .raddr(rd_idx),
    .rdata(ram_row)
  );

  // Working stage: item, sampled valid bit and forwarded row
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_full <= 1'b0;
      byp_hit <= 1'b0;
    end else begin
      if (accept) begin
        s1_full <= 1'b1;
        byp_hit <= ram_we && (s1_item.channel == req.channel);
      end else if (s1_adv) begin
        s1_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= req;
      s1_vld  <= vld[rd_idx];
      byp_row <= wr.row;
    end
  end

  // Pick the current row: forwarded, stored, or fresh after init
  always_comb begin
    if (byp_hit) begin
      s1_row = byp_row;
    end else if (s1_vld) begin
      s1_row = ram_row;
    end else begin
      s1_row = init_row(conv_max(cfg.resolution_bits));
    end
  end

  sracd_calc #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_calc (
    .item(s1_item),
    .row (s1_row),
    .cfg (cfg),
    .rsp (rsp_next),
    .wr  (wr)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (s1_adv) begin
      out_full <= 1'b1;
    end else if (!rsp_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp <= rsp_next;
    end
  end

`include "sensor_range_autocal_detent_assert.svh"

  `SRACD_ASSERT_NOW(a_write_on_advance, ram_we, s1_full && s1_adv)
  `SRACD_ASSERT_NOW(a_hold_when_blocked, s1_full && out_full && rsp_stall, req_stall)
  `SRACD_ASSERT_NOW(a_reject_zero_value, rsp_valid && rsp.status, rsp.value_out == 16'd0)
  `SRACD_ASSERT_NEXT(a_accept_fills_stage, accept, s1_full)

endmodule

### test/tb.sv
// Testbench of the sensor range calibration block: directed and random request beats,
// each checked against an in-bench calibration predictor as its response beat comes back.
// Depends on sracd_pkg and the sensor_range_autocal_detent RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sracd_pkg::*;

  localparam int NCH = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LATENCY_TAIL = 8;
  localparam int PHASE_BEATS = 103;
  // Request code the block does not define
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // Predictor copy of the registers and the per-channel tables
  logic [4:0]  cal_res;
  logic [4:0]  cal_active;
  logic [15:0] cal_mask;
  logic [15:0] min_tab [NCH];
  logic [15:0] max_tab [NCH];
  logic [15:0] dlo_tab [NCH];
  logic [15:0] dhi_tab [NCH];

  rsp_t due_reports [$];
  int   fail_count;
  int   quiet_cycles;
  bit   steady;

  sensor_range_autocal_detent #(.NUM_CHANNELS(NCH)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Converter full scale for a resolution setting
  function automatic int unsigned full_scale(input logic [4:0] bits);
    int unsigned b;
    b = (bits > 5'd16) ? 16 : bits;
    if (b == 16) begin
      return 65535;
    end
    return 1 << b;
  endfunction

  function automatic void reload_tables();
    int unsigned fs;
    fs = full_scale(cal_res);
    for (int i = 0; i < NCH; i++) begin
      min_tab[i] = 16'(fs);
      max_tab[i] = 16'd0;
      dlo_tab[i] = 16'd0;
      dhi_tab[i] = 16'(fs);
    end
  endfunction

  function automatic void apply_register(input logic [1:0] idx, input logic [15:0] data);
    case (idx)
      CFG_RESOLUTION: begin
        cal_res = data[4:0];
        reload_tables();
      end
      CFG_ACTIVE: cal_active = data[4:0];
      CFG_MASK:   cal_mask = data;
      default: ;
    endcase
  endfunction

  // Update the tables for one request and return the report it should produce
  function automatic rsp_t calibrate_item(input req_t r);
    rsp_t        o;
    int unsigned ch, lim, fs, v, span, mid, half, lo, hi;
    logic        en;
    o = '0;
    ch = r.channel;
    lim = (cal_active > NCH) ? NCH : cal_active;
    // Out-of-range channel: reject with every other field cleared
    if (ch >= lim || ch >= NCH) begin
      o.status = 1'b1;
      return o;
    end
    en = cal_mask[ch];
    if (r.req_type == REQ_SAMPLE) begin
      fs = full_scale(cal_res);
      v = (r.value_in > fs) ? fs : r.value_in;
      o.value_out = 16'(v);
      if (en) begin
        if (v < min_tab[ch]) min_tab[ch] = 16'(v);
        if (v > max_tab[ch]) max_tab[ch] = 16'(v);
        if (max_tab[ch] < min_tab[ch]) max_tab[ch] = min_tab[ch];
        span = max_tab[ch] - min_tab[ch];
        if (span == 0) span = 1;
        mid = min_tab[ch] + span / 2;
        half = span / 40;
        lo = (mid > half) ? mid - half : 0;
        hi = mid + half;
        if (hi > fs) hi = fs;
        dlo_tab[ch] = 16'(lo);
        dhi_tab[ch] = 16'(hi);
      end
    end else if (r.req_type == REQ_SET_LOW || r.req_type == REQ_SET_HIGH) begin
      if (!en) begin
        o.status = 1'b1;
      end else if (r.req_type == REQ_SET_HIGH) begin
        dhi_tab[ch] = r.value_in;
      end else begin
        dlo_tab[ch] = r.value_in;
      end
    end else begin
      o.status = 1'b1;
    end
    o.chan_enabled = en;
    o.min_seen = min_tab[ch];
    o.max_seen = max_tab[ch];
    o.detent_low = dlo_tab[ch];
    o.detent_high = dhi_tab[ch];
    return o;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  // Check response beats first, then predict newly accepted request beats
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (due_reports.size() == 0) begin
          $error("response beat with nothing outstanding: %h", rsp);
          fail_count++;
        end else begin
          want = due_reports.pop_front();
          check_field("status", 16'(want.status), 16'(rsp.status));
          check_field("value_out", want.value_out, rsp.value_out);
          check_field("chan_enabled", 16'(want.chan_enabled), 16'(rsp.chan_enabled));
          check_field("min_seen", want.min_seen, rsp.min_seen);
          check_field("max_seen", want.max_seen, rsp.max_seen);
          check_field("detent_low", want.detent_low, rsp.detent_low);
          check_field("detent_high", want.detent_high, rsp.detent_high);
        end
      end
      if (req_valid && !req_stall) due_reports.push_back(calibrate_item(req));
      if (cfg_valid && cfg_ready) apply_register(cfg_index, cfg_data);
    end
  end

  // Abort when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stall the response side at random, except in steady stretches
  always @(negedge clk) begin
    rsp_stall <= !steady && ($urandom_range(99) < 11);
  end

  // Drive one request beat; valid is left high for the caller's next beat
  task automatic send_beat(input logic [1:0] kind, input logic [7:0] ch,
                           input logic [15:0] val);
    while (!steady && $urandom_range(99) < 11) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{req_type: kind, channel: ch, value_in: val};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off requests until every outstanding report has arrived
  task automatic settle();
    req_valid <= 1'b0;
    while (due_reports.size() != 0) @(negedge clk);
    repeat (LATENCY_TAIL) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] res, input logic [15:0] act,
                            input logic [15:0] mask);
    settle();
    write_reg(CFG_RESOLUTION, res);
    write_reg(CFG_ACTIVE, act);
    write_reg(CFG_MASK, mask);
    cfg_valid <= 1'b0;
  endtask

  // Reset settings: every channel disabled, 12-bit converter
  task automatic test_reset_state();
    send_beat(REQ_SAMPLE, 8'd0, 16'hFFFF);
    send_beat(REQ_SAMPLE, 8'd15, 16'd100);
    send_beat(REQ_SET_LOW, 8'd3, 16'h1234);
    send_beat(REQ_SET_HIGH, 8'd3, 16'h0FFF);
    send_beat(REQ_UNUSED, 8'd0, 16'h5555);
    send_beat(REQ_SAMPLE, 8'd16, 16'd7);
    send_beat(REQ_SAMPLE, 8'hFF, 16'hFFFF);
  endtask

  // Every request kind on enabled channels, clamping and unclamped detents
  task automatic test_request_kinds();
    set_config(16'd12, 16'd16, 16'hFFFF);
    send_beat(REQ_SAMPLE, 8'd0, 16'd0);
    send_beat(REQ_SAMPLE, 8'd0, 16'd4095);
    send_beat(REQ_SAMPLE, 8'd0, 16'hFFFF);
    send_beat(REQ_SET_LOW, 8'd0, 16'hFFFF);
    send_beat(REQ_SET_HIGH, 8'd0, 16'd0);
    send_beat(REQ_SAMPLE, 8'd0, 16'd2000);
    send_beat(REQ_UNUSED, 8'd0, 16'hAAAA);
    send_beat(REQ_SAMPLE, 8'd1, 16'd1000);
    send_beat(REQ_SAMPLE, 8'd2, 16'd4096);
  endtask

  // No channels, a partial count with gaps in the mask, and a count above the table
  task automatic test_active_count();
    set_config(16'd12, 16'd0, 16'hFFFF);
    send_beat(REQ_SAMPLE, 8'd0, 16'd10);
    set_config(16'd12, 16'd5, 16'h0015);
    send_beat(REQ_SAMPLE, 8'd4, 16'd300);
    send_beat(REQ_SAMPLE, 8'd5, 16'd300);
    send_beat(REQ_SET_LOW, 8'd3, 16'd9);
    set_config(16'd12, 16'd31, 16'hFFFF);
    send_beat(REQ_SAMPLE, 8'd15, 16'd77);
    send_beat(REQ_SAMPLE, 8'd16, 16'd77);
  endtask

  // Narrowest and widest converter, and a resolution written with high bits set
  task automatic test_resolution_extremes();
    set_config(16'd0, 16'd16, 16'hFFFF);
    send_beat(REQ_SAMPLE, 8'd0, 16'd0);
    send_beat(REQ_SAMPLE, 8'd0, 16'hFFFF);
    set_config(16'd16, 16'd16, 16'hFFFF);
    send_beat(REQ_SAMPLE, 8'd0, 16'd0);
    send_beat(REQ_SAMPLE, 8'd0, 16'hFFFF);
    set_config(16'hFFFF, 16'hFFF0, 16'hFFFF);
    send_beat(REQ_SAMPLE, 8'd1, 16'hFFFF);
    send_beat(REQ_SAMPLE, 8'd1, 16'h1234);
  endtask

  // Mostly samples on live channels so the windows keep moving; some sets and noise
  task automatic random_beat();
    int unsigned p, q, fs;
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [15:0] val;
    fs = full_scale(cal_res);
    p = $urandom_range(99);
    kind = (p < 75) ? REQ_SAMPLE : (p < 86) ? REQ_SET_LOW :
           (p < 96) ? REQ_SET_HIGH : REQ_UNUSED;
    ch = ($urandom_range(99) < 8) ? 8'($urandom) : 8'($urandom_range(NCH - 1));
    q = $urandom_range(99);
    if (kind != REQ_SAMPLE || q < 15) begin
      val = 16'($urandom);
    end else if (q < 25) begin
      val = ($urandom_range(1) != 0) ? 16'(fs) : 16'd0;
    end else begin
      val = 16'($urandom_range(fs));
    end
    send_beat(kind, ch, val);
  endtask

  task automatic test_random_traffic();
    logic [15:0] res_set [8];
    logic [15:0] act_set [8];
    logic [15:0] mask_set [8];
    res_set = '{16'd12, 16'd8, 16'd16, 16'd0, 16'd4, 16'd20, 16'd10, 16'd1};
    act_set = '{16'd16, 16'd16, 16'd31, 16'd16, 16'd7, 16'd16, 16'd12, 16'd16};
    mask_set = '{16'hFFFF, 16'($urandom), 16'hFFFF, 16'hAAAA,
                 16'($urandom), 16'($urandom), 16'h5555, 16'hFFFF};
    for (int ph = 0; ph < 8; ph++) begin
      set_config(res_set[ph], act_set[ph], mask_set[ph]);
      steady = (ph == 2);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // Let the pipeline run dry once mid-phase
        if (ph == 4 && n == PHASE_BEATS / 2) settle();
        random_beat();
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RESOLUTION;
    cfg_data = '0;
    steady = 1'b0;
    fail_count = 0;
    quiet_cycles = 0;
    cal_res = RESOLUTION_RESET;
    cal_active = ACTIVE_RESET;
    cal_mask = MASK_RESET;
    reload_tables();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_request_kinds();
    test_active_count();
    test_resolution_extremes();
    test_random_traffic();

    settle();
    if (due_reports.size() != 0) begin
      $error("%0d reports never arrived", due_reports.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
